>>> rtl/core/csvt_pkg.sv
package csvt_pkg;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // configuration register indexes
    localparam logic CFG_DELIM = 1'b0;
    localparam logic CFG_QUOTE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNTERM = 2'd1;
    localparam logic [1:0] ST_STRAY  = 2'd2;

    // result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_UNQ      = 3'd1,
        MODE_QUOTED   = 3'd2,
        MODE_AFTER_CR = 3'd3,
        MODE_STOP     = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       row_end;
        logic [1:0] status;
        logic       run_last;
    } t_out;

    // results of one input byte: up to two items
    typedef struct packed {
        t_out       item0;
        t_out       item1;
        logic [1:0] count;
    } t_res;

    function automatic t_out mk_item(logic [7:0] b, logic v, logic fe, logic re,
                                     logic [1:0] st);
        t_out r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.field_end  = fe;
        r.row_end    = re;
        r.status     = st;
        r.run_last   = 1'b0;
        return r;
    endfunction

    // field end item: a pending lone quote carries the marks
    function automatic t_out end_item(logic pq, logic [7:0] q, logic re);
        t_out r;
        if (pq) begin
            r = mk_item(q, 1'b1, 1'b1, re, ST_OK);
        end else begin
            r = mk_item(8'd0, 1'b0, 1'b1, re, ST_OK);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/csvt_parse.sv
module csvt_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  csvt_pkg::t_in  i_item,
    input  logic [7:0]     i_delim,
    input  logic [7:0]     i_quote,
    output csvt_pkg::t_res o_res
);
    import csvt_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_pq, n_pq;

    always_comb begin
        logic [7:0] b;
        logic       fin;
        logic       eol;
        t_mode      after_eol;
        t_mode      m;
        logic       pq;
        t_out       e0;
        t_out       e1;
        logic [1:0] cnt;

        b         = i_item.in_byte;
        fin       = i_item.is_final;
        eol       = (b == CH_CR) || (b == CH_LF);
        after_eol = (b == CH_CR) ? MODE_AFTER_CR : MODE_START;
        m         = r_mode;
        pq        = r_pq;
        n_mode    = r_mode;
        n_pq      = r_pq;
        e0        = '0;
        e1        = '0;
        cnt       = 2'd0;

        // LF straight after CR is swallowed
        if (r_mode == MODE_AFTER_CR) begin
            n_mode = MODE_START;
            m      = (b == CH_LF) ? MODE_STOP : MODE_START;
        end

        if (m == MODE_START) begin
            if (b == i_quote) begin
                n_mode = MODE_QUOTED;
                n_pq   = 1'b0;
                if (fin) begin
                    e0  = mk_item(8'd0, 1'b0, 1'b0, 1'b0, ST_UNTERM);
                    cnt = 2'd1;
                end
            end else if (eol) begin
                e0     = end_item(pq, i_quote, 1'b1);
                cnt    = 2'd1;
                n_pq   = 1'b0;
                n_mode = after_eol;
            end else if (b == i_delim) begin
                e0   = end_item(pq, i_quote, fin);
                cnt  = 2'd1;
                n_pq = 1'b0;
            end else begin
                pq = 1'b0;
                m  = MODE_UNQ;
            end
        end

        unique case (m)
            MODE_UNQ: begin
                n_mode = MODE_UNQ;
                if (eol) begin
                    e0     = end_item(pq, i_quote, 1'b1);
                    cnt    = 2'd1;
                    n_pq   = 1'b0;
                    n_mode = after_eol;
                end else if (b == i_delim) begin
                    e0     = end_item(pq, i_quote, fin);
                    cnt    = 2'd1;
                    n_pq   = 1'b0;
                    n_mode = MODE_START;
                end else begin
                    if (b == i_quote) begin
                        if (pq) begin
                            e0  = mk_item(i_quote, 1'b1, 1'b0, 1'b0, ST_OK);
                            cnt = 2'd1;
                            pq  = 1'b0;
                        end else begin
                            pq = 1'b1;
                        end
                    end else begin
                        if (pq) begin
                            e0  = mk_item(i_quote, 1'b1, 1'b0, 1'b0, ST_OK);
                            e1  = mk_item(b, 1'b1, 1'b0, 1'b0, ST_OK);
                            cnt = 2'd2;
                        end else begin
                            e0  = mk_item(b, 1'b1, 1'b0, 1'b0, ST_OK);
                            cnt = 2'd1;
                        end
                        pq = 1'b0;
                    end
                    if (fin) begin
                        // a lone quote at text end is only possible with nothing emitted
                        if (pq) begin
                            e0  = mk_item(i_quote, 1'b1, 1'b0, 1'b0, ST_OK);
                            cnt = 2'd1;
                            pq  = 1'b0;
                        end
                        case (cnt)
                            2'd2: begin
                                e1.field_end = 1'b1;
                                e1.row_end   = 1'b1;
                            end
                            2'd1: begin
                                e0.field_end = 1'b1;
                                e0.row_end   = 1'b1;
                            end
                            default: begin
                                e0  = mk_item(8'd0, 1'b0, 1'b1, 1'b1, ST_OK);
                                cnt = 2'd1;
                            end
                        endcase
                    end
                    n_pq = pq;
                end
            end
            MODE_QUOTED: begin
                if (pq) begin
                    n_pq = 1'b0;
                    if (b == i_quote) begin
                        e0  = mk_item(i_quote, 1'b1, 1'b0, 1'b0, ST_OK);
                        cnt = 2'd1;
                        if (fin) begin
                            e1  = mk_item(8'd0, 1'b0, 1'b0, 1'b0, ST_UNTERM);
                            cnt = 2'd2;
                        end
                    end else if (eol) begin
                        e0     = mk_item(8'd0, 1'b0, 1'b1, 1'b1, ST_OK);
                        cnt    = 2'd1;
                        n_mode = after_eol;
                    end else if (b == i_delim) begin
                        e0     = mk_item(8'd0, 1'b0, 1'b1, fin, ST_OK);
                        cnt    = 2'd1;
                        n_mode = MODE_START;
                    end else begin
                        e0     = mk_item(8'd0, 1'b0, 1'b0, 1'b0, ST_STRAY);
                        cnt    = 2'd1;
                        n_mode = MODE_STOP;
                    end
                end else if (b == i_quote) begin
                    n_pq = 1'b1;
                    if (fin) begin
                        e0   = mk_item(8'd0, 1'b0, 1'b1, 1'b1, ST_OK);
                        cnt  = 2'd1;
                        n_pq = 1'b0;
                    end
                end else begin
                    e0  = mk_item(b, 1'b1, 1'b0, 1'b0, ST_OK);
                    cnt = 2'd1;
                    if (fin) begin
                        e1  = mk_item(8'd0, 1'b0, 1'b0, 1'b0, ST_UNTERM);
                        cnt = 2'd2;
                    end
                end
            end
            default: begin
            end
        endcase

        case (cnt)
            2'd2:    e1.run_last = 1'b1;
            2'd1:    e0.run_last = 1'b1;
            default: begin
            end
        endcase

        if (fin) begin
            n_mode = MODE_START;
            n_pq   = 1'b0;
        end

        o_res.item0 = e0;
        o_res.item1 = e1;
        o_res.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_pq   <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_pq   <= n_pq;
        end
    end

endmodule

>>> rtl/core/csvt_outq.sv
module csvt_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csvt_pkg::t_res i_res,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output csvt_pkg::t_out o_data
);
    import csvt_pkg::*;

    t_out             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             pop;
    logic [QCW-1:0]   push_n;

    assign pop     = o_valid && !i_stall;
    assign push_n  = i_push ? QCW'(i_res.count) : '0;
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCW'(QDEPTH - 2));
    assign o_data  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp + QAW'(push_n);
        n_rp  = r_rp + QAW'(pop);
        n_cnt = r_cnt + push_n - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_res.count != 2'd0) begin
            r_q[r_wp] <= i_res.item0;
        end
        if (i_push && i_res.count == 2'd2) begin
            r_q[r_wp + QAW'(1)] <= i_res.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/csv_field_tokenizer.sv
// CSV field tokenizer.
// Input channel: i_valid / o_stall with one text byte and its end-of-text
// flag in i_data; a transaction happens when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall with one result item in o_data; each
// input byte gives zero, one or two items, the last one flagged run_last.
// Configuration: i_cfg_we writes i_cfg_wdata to the delimiter (index 0) or
// quote (index 1) register; write only while no byte is in flight.
// Path: a byte passes the input register, then the parser into the result
// queue, and o_valid shows its first item once it is in the queue; a queue
// without room holds the byte in the input register. One byte per cycle is
// taken while bytes give at most one item each and the receiver does not
// stall; a two-item byte sends its items one by one through the output port.
// Reset (synchronous, active low) empties the result queue, drops a held
// byte, returns the parser to the start of a field and restores comma and
// double quote. While the receiver stalls, the head item holds; once the
// 4-entry queue holds three items and a byte waits, o_stall rises until
// room is back.
module csv_field_tokenizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  csvt_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output csvt_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_wdata
);
    import csvt_pkg::*;

    logic [7:0] r_delim;
    logic [7:0] r_quote;
    logic       r_in_valid;
    t_in        r_in;
    logic       room;
    logic       adv;
    t_res       res;

    assign adv     = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_quote <= QUOTE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DELIM) begin
                r_delim <= i_cfg_wdata;
            end else begin
                r_quote <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    csvt_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in),
        .i_delim (r_delim),
        .i_quote (r_quote),
        .o_res   (res)
    );

    csvt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

>>> rtl/core/csvt_checker.sv
module csvt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input csvt_pkg::t_out o_data
);
    import csvt_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    a_status_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |->
            !o_data.byte_valid && !o_data.field_end && !o_data.row_end
            && o_data.run_last)
        else $error("error item carries content or marks");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.out_byte == 8'd0)
        else $error("out_byte set without byte_valid");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
